// ===== src/sm4cbc_pkg.sv =====
`default_nettype none
package sm4cbc_pkg;

   localparam int ROUNDS = 32;
   localparam int RIDX_W = 5;

   localparam logic [2:0] CSR_KEY0 = 3'd0;
   localparam logic [2:0] CSR_KEY1 = 3'd1;
   localparam logic [2:0] CSR_KEY2 = 3'd2;
   localparam logic [2:0] CSR_KEY3 = 3'd3;
   localparam logic [2:0] CSR_IVHI = 3'd4;
   localparam logic [2:0] CSR_IVLO = 3'd5;
   localparam logic [2:0] CSR_DIR  = 3'd6;

   localparam logic [127:0] FK = {32'ha3b1bac6, 32'h56aa3350, 32'h677d9197, 32'hb27022dc};

   typedef struct packed {
      logic load;     // load a new block into all four cells
      logic step;     // shift all cells one place and run one round
      logic key_mode; // key schedule round instead of data round
   } ctl_type;

   function automatic logic [7:0] sbox(input logic [7:0] a);
      logic [7:0] t [0:255];
      t = '{
      8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
      8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
      8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
      8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
      8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
      8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
      8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
      8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
      8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
      8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
      8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
      8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
      8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
      8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
      8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
      8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48};
      return t[a];
   endfunction

   // Round constant i: byte j is (4*i+j)*7 mod 256.
   function automatic logic [31:0] ck(input logic [RIDX_W-1:0] i);
      logic [7:0] b0;
      b0 = {i, 2'b00} * 8'd7;
      return {b0, b0 + 8'd7, b0 + 8'd14, b0 + 8'd21};
   endfunction

   function automatic logic [31:0] t_fn(input logic [31:0] x, input logic key_mode);
      logic [31:0] b;
      b = {sbox(x[31:24]), sbox(x[23:16]), sbox(x[15:8]), sbox(x[7:0])};
      if (key_mode)
         return b ^ {b[18:0], b[31:19]} ^ {b[8:0], b[31:9]};
      return b ^ {b[29:0], b[31:30]} ^ {b[21:0], b[31:22]} ^ {b[13:0], b[31:14]}
             ^ {b[7:0], b[31:8]};
   endfunction

endpackage
`default_nettype wire

// ===== src/sm4cbc_cell.sv =====
`default_nettype none
// One word of the four-word shift chain.
module sm4cbc_cell (
   input  wire logic                  clock,
   input  wire sm4cbc_pkg::ctl_type   ctl,
   input  wire logic [31:0]           load_word,
   input  wire logic [31:0]           shift_in,
   output logic [31:0]                word_out
);
   logic [31:0] word_ff;
   logic [31:0] word_in;

   always_comb begin
      word_in = word_ff;
      if (ctl.load) word_in = load_word;
      else if (ctl.step) word_in = shift_in;
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word_out = word_ff;
endmodule
`default_nettype wire

// ===== src/sm4cbc_round.sv =====
`default_nettype none
// Round function that feeds the new word back into the chain of cells.
module sm4cbc_round (
   input  wire logic                  clock,
   input  wire sm4cbc_pkg::ctl_type   ctl,
   input  wire logic [127:0]          load_block,
   input  wire logic [31:0]           round_key,
   output logic [127:0]               block_out
);
   logic [31:0] w [0:3];
   logic [31:0] new_word;

   assign new_word = w[0] ^ sm4cbc_pkg::t_fn(w[1] ^ w[2] ^ w[3] ^ round_key, ctl.key_mode);

   genvar g;
   generate
      for (g = 0; g < 4; g++) begin : g_cell
         sm4cbc_cell u_cell (
            .clock     (clock),
            .ctl       (ctl),
            .load_word (load_block[127-32*g -: 32]),
            .shift_in  ((g == 3) ? new_word : w[(g+1)%4]),
            .word_out  (w[g])
         );
      end
   endgenerate

   assign block_out = {w[0], w[1], w[2], w[3]};
endmodule
`default_nettype wire

// ===== src/sm4_cbc_cipher_top.sv =====
`default_nettype none
// SM4-128 CBC cipher with PKCS#7 padding.
// req_ carries one 128-bit block word; rsp_ returns result words. csr_ writes the
// key words, the IV halves and the direction (0 encrypt, 1 decrypt); the user must
// do so only while idle, as the block itself does not enforce it. A word with
// first_block set first runs the key schedule (one load and 32 rounds) on the
// round unit and reloads the chain from the IV. Each block then takes one load
// and 32 rounds, one per cycle, on one shared round unit built from four word
// cells; the result is registered in the cycle after the last round.
// An encrypted full last block yields a second word of padding once the first
// result is taken. Decrypt last words are checked for padding and carry
// out_bytes and pad_error. The block takes a new req_ word only once the
// previous result has been taken, in the cycle after that handshake at the
// earliest, so a stalled receiver stalls the input.
// Reset (synchronous, active high) returns the control to idle and clears the
// chain, the key and IV registers and the direction.
module sm4_cbc_cipher_top (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire logic [135:0]  req_tdata,  // 3'b0, byte_count, data_lo, data_hi
   input  wire logic          req_tuser,  // first_block
   input  wire logic          req_tlast,  // last_block
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output logic [135:0]       rsp_tdata,  // 3'b0, out_bytes, out_lo, out_hi
   output logic               rsp_tuser,  // pad_error
   output logic               rsp_tlast,  // last_result
   input  wire logic          csr_we,
   input  wire logic [2:0]    csr_addr,
   input  wire logic [63:0]   csr_wdata
);
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_KEY  = 3'd1;
   localparam logic [2:0] S_LOAD = 3'd2;
   localparam logic [2:0] S_RUN  = 3'd3;
   localparam logic [2:0] S_DONE = 3'd4;
   localparam logic [2:0] S_OUT  = 3'd5;

   logic [2:0]   state_ff, state_in;
   logic [4:0]   cnt_ff, cnt_in;
   logic [127:0] key_ff;
   logic [127:0] iv_ff;
   logic         dir_ff;
   logic [127:0] chain_ff, chain_in;
   logic [127:0] data_ff;
   logic [4:0]   count_ff;
   logic         last_ff, first_ff, pad_pending_ff, pad_pending_in;
   logic [31:0]  rk_mem [0:sm4cbc_pkg::ROUNDS-1];
   logic [31:0]  rk_rd_ff;
   logic [4:0]   rd_addr;
   logic         rsp_valid_ff;
   logic [127:0] out_ff;
   logic [4:0]   out_bytes_ff;
   logic         out_last_ff, out_err_ff;

   sm4cbc_pkg::ctl_type ctl;
   logic [127:0] load_block, blk;
   logic [31:0]  round_key;

   sm4cbc_round u_round (
      .clock      (clock),
      .ctl        (ctl),
      .load_block (load_block),
      .round_key  (round_key),
      .block_out  (blk)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0; iv_ff <= '0; dir_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_addr)
            sm4cbc_pkg::CSR_KEY0: key_ff[127:96] <= csr_wdata[31:0];
            sm4cbc_pkg::CSR_KEY1: key_ff[95:64]  <= csr_wdata[31:0];
            sm4cbc_pkg::CSR_KEY2: key_ff[63:32]  <= csr_wdata[31:0];
            sm4cbc_pkg::CSR_KEY3: key_ff[31:0]   <= csr_wdata[31:0];
            sm4cbc_pkg::CSR_IVHI: iv_ff[127:64]  <= csr_wdata;
            sm4cbc_pkg::CSR_IVLO: iv_ff[63:0]    <= csr_wdata;
            sm4cbc_pkg::CSR_DIR:  dir_ff         <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign req_tready = (state_ff == S_IDLE) && !pad_pending_ff && !rsp_valid_ff;
   wire req_acc = req_tvalid && req_tready;

   // Padded plaintext for an encrypt last word.
   logic [127:0] padded;
   logic [4:0]   cnt_sat;
   always_comb begin
      cnt_sat = (count_ff > 5'd16) ? 5'd16 : count_ff;
      padded = data_ff;
      if (last_ff) begin
         for (int i = 0; i < 16; i++) begin
            if (5'(i) >= cnt_sat) padded[127-8*i -: 8] = 8'(5'd16 - cnt_sat);
         end
      end
   end

   assign rd_addr = dir_ff ? 5'(5'd31 - cnt_in) : cnt_in;
   assign round_key = (state_ff == S_KEY) ? sm4cbc_pkg::ck(cnt_ff) : rk_rd_ff;

   logic [127:0] swapped;
   assign swapped = {blk[31:0], blk[63:32], blk[95:64], blk[127:96]};

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      pad_pending_in = pad_pending_ff;
      ctl = '0;
      load_block = padded ^ chain_ff;
      chain_in = chain_ff;
      case (state_ff)
         S_IDLE: begin
            if (pad_pending_ff && !rsp_valid_ff) begin
               state_in = S_LOAD;
               cnt_in = '0;
            end else if (req_acc) begin
               state_in = req_tuser ? S_KEY : S_LOAD;
               cnt_in = '0;
               if (req_tuser) chain_in = iv_ff;
            end
         end
         S_KEY: begin
            if (first_ff) begin
               ctl.load = 1'b1;
               load_block = key_ff ^ sm4cbc_pkg::FK;
            end else begin
               ctl.step = 1'b1;
               ctl.key_mode = 1'b1;
               cnt_in = cnt_ff + 5'd1;
               if (cnt_ff == 5'd31) begin
                  state_in = S_LOAD;
                  cnt_in = '0;
               end
            end
         end
         S_LOAD: begin
            ctl.load = 1'b1;
            if (pad_pending_ff) load_block = {16{8'h10}} ^ chain_ff;
            else if (dir_ff) load_block = data_ff;
            state_in = S_RUN;
         end
         S_RUN: begin
            ctl.step = 1'b1;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) state_in = S_DONE;
         end
         S_DONE: begin
            state_in = S_IDLE;
            if (pad_pending_ff) pad_pending_in = 1'b0;
            else if (!dir_ff && last_ff && cnt_sat == 5'd16) pad_pending_in = 1'b1;
            chain_in = dir_ff ? data_ff : swapped;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Padding check on the decrypted block.
   logic [127:0] plain;
   logic [7:0]   p;
   logic         pad_ok;
   assign plain = swapped ^ chain_ff;
   assign p = plain[7:0];
   always_comb begin
      pad_ok = (p >= 8'd1) && (p <= 8'd16);
      for (int i = 0; i < 16; i++) begin
         if ((8'(i) >= 8'd16 - p) && plain[127-8*i -: 8] != p) pad_ok = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_KEY && !first_ff) rk_mem[cnt_ff] <= blk[31:0] ^
         sm4cbc_pkg::t_fn(blk[95:64] ^ blk[63:32] ^ blk[31:0] ^ sm4cbc_pkg::ck(cnt_ff), 1'b1)
         ^ blk[127:96] ^ blk[31:0];
      rk_rd_ff <= rk_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; cnt_ff <= '0; chain_ff <= '0;
         pad_pending_ff <= 1'b0; rsp_valid_ff <= 1'b0; first_ff <= 1'b0;
      end else begin
         state_ff <= state_in; cnt_ff <= cnt_in; chain_ff <= chain_in;
         pad_pending_ff <= pad_pending_in;
         first_ff <= req_acc && req_tuser;
         if (state_ff == S_DONE) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end
      if (req_acc) begin
         data_ff <= {req_tdata[63:0], req_tdata[127:64]};
         count_ff <= req_tdata[132:128];
         last_ff <= req_tlast;
      end
      if (state_ff == S_DONE) begin
         if (dir_ff) begin
            out_ff <= plain;
            out_last_ff <= last_ff;
            out_err_ff <= last_ff && !pad_ok;
            out_bytes_ff <= (last_ff && pad_ok) ? 5'(8'd16 - p) : 5'd16;
         end else begin
            out_ff <= swapped;
            out_bytes_ff <= 5'd16;
            out_err_ff <= 1'b0;
            out_last_ff <= pad_pending_ff || (last_ff && cnt_sat != 5'd16);
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {3'b000, out_bytes_ff, out_ff[63:0], out_ff[127:64]};
   assign rsp_tuser = out_err_ff;
   assign rsp_tlast = out_last_ff;
endmodule
`default_nettype wire

// ===== src/sm4cbc_checker.sv =====
`default_nettype none
module sm4cbc_checker (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_tvalid,
   input wire logic         req_tready,
   input wire logic         rsp_tvalid,
   input wire logic         rsp_tready,
   input wire logic         rsp_tuser,
   input wire logic         rsp_tlast,
   input wire logic [135:0] rsp_tdata
);
   a_err_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast) else $error("pad error off last word");
   a_err_bytes: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[132:128] == 5'd16) else $error("bad byte count");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready) else $error("input taken with result pending");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid) else $error("result dropped");
endmodule

bind sm4_cbc_cipher_top sm4cbc_checker u_checker (.*);
`default_nettype wire
